// ===== rtl/utf16_to_utf8_encoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_unit_defines.svh
// Assertion macros shared by the UTF-16 to UTF-8 encoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_ENCODER_UNIT_DEFINES_SVH
`define UTF16_TO_UTF8_ENCODER_UNIT_DEFINES_SVH

// Plain invariant, checked at every rising clock edge outside reset.
`define U16U8_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define U16U8_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/u16u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types, constants and the code point encoder of the UTF-16 to UTF-8 unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

  // Upper six bits of a high / low surrogate (0xD800..0xDBFF, 0xDC00..0xDFFF)
  localparam logic [5:0]  SURR_HI_TAG  = 6'b110110;
  localparam logic [5:0]  SURR_LO_TAG  = 6'b110111;
  localparam logic [20:0] CP_SUPP_BASE = 21'h10000;
  localparam logic [20:0] LIM_1B       = 21'h0007F;
  localparam logic [20:0] LIM_2B       = 21'h007FF;
  localparam logic [20:0] LIM_3B       = 21'h0FFFF;
  localparam int unsigned JOB_BYTES    = 6;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       end_of_string;
  } out_item_t;

  // Encoded code point, b[0] goes out first
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } enc_t;

  // One queued job: all bytes caused by one input transfer
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      bvalid;
    logic                      eos;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic enc_t encode_cp(input logic [20:0] cp);
    enc_t r;
    r = '0;
    if (cp <= LIM_1B) begin
      r.b[0] = {1'b0, cp[6:0]};
      r.n    = 3'd1;
    end else if (cp <= LIM_2B) begin
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
      r.n    = 3'd2;
    end else if (cp <= LIM_3B) begin
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
      r.n    = 3'd3;
    end else begin
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
      r.n    = 3'd4;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/utf16_to_utf8_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_unit
// UTF-16 code unit stream in, UTF-8 byte stream out.
// ----------------------------------------------------------------------------
// One code unit is taken per input transfer; each output transfer carries one
// UTF-8 byte. The front stage can take a new unit every cycle while the job
// queue (FIFO_DEPTH entries) has room, so in_stall_o is simply "queue full".
// The back stage sends one byte per cycle while out_stall_i is low. An item
// yields 1 to 3 bytes for a BMP unit, 4 for a surrogate pair, and up to 6
// when a held high surrogate is flushed ahead of a new unit. Units that give
// no bytes (a high surrogate being held, or anything while the text is
// stopped) reach the back stage not at all. Sustained rate is therefore set
// by the byte serializer and the bytes per item. No clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_encoder_unit
  import u16u8_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  // input channel: one UTF-16 code unit per transfer
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  // output channel: one UTF-8 byte per transfer
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  logic    push, pop;
  job_t    wr_job, rd_job;
  q_stat_t q_stat;

  // Front stalls on queue full only; it never looks at the output side.
  assign in_stall_o = q_stat.full;

  // Front: surrogate pairing, stop state, builds the full byte job per unit.
  u16u8_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (wr_job)
  );

  // Queue decouples unit intake from byte output.
  u16u8_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wr_job_i (wr_job),
    .pop_i    (pop),
    .rd_job_o (rd_job),
    .stat_o   (q_stat)
  );

  // Back: walks each job byte by byte, marks last-of-run and end-of-string.
  u16u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_job_i    (rd_job),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/u16u8_front.sv =====
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, tracks surrogate and stop state, builds byte jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u16u8_front
  import u16u8_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire in_item_t in_data_i,
  input  wire q_stat_t  q_stat_i,
  output logic          push_o,
  output job_t          job_o
);

  logic       pend_q, pend_d;
  logic [9:0] pend_hi_q, pend_hi_d;
  logic       stopped_q, stopped_d;

  logic        accept;
  logic        is_zero, is_high, is_low, eot;
  logic [20:0] cp_pair, cp_sel;
  enc_t        enc, enc_fl;
  logic        do_flush, do_enc, need_push;
  logic [2:0]  enc_n;

  assign accept  = in_valid_i && !q_stat_i.full;
  assign eot     = in_data_i.end_of_text;
  assign is_zero = (in_data_i.code_unit == 16'h0000);
  assign is_high = (in_data_i.code_unit[15:10] == SURR_HI_TAG);
  assign is_low  = (in_data_i.code_unit[15:10] == SURR_LO_TAG);

  assign cp_pair = CP_SUPP_BASE + {1'b0, pend_hi_q, in_data_i.code_unit[9:0]};
  assign cp_sel  = (pend_q && is_low) ? cp_pair : {5'b0, in_data_i.code_unit};
  assign enc     = encode_cp(cp_sel);
  assign enc_fl  = encode_cp({5'b0, SURR_HI_TAG, pend_hi_q});

  always_comb begin
    pend_d    = pend_q;
    pend_hi_d = pend_hi_q;
    stopped_d = stopped_q;
    do_flush  = 1'b0;
    do_enc    = 1'b0;
    need_push = 1'b0;
    job_o     = '0;
    if (stopped_q) begin
      if (eot) begin
        stopped_d = 1'b0;
      end
    end else if (is_zero) begin
      do_flush  = pend_q;
      need_push = 1'b1;
      pend_d    = 1'b0;
      stopped_d = !eot;
    end else if (pend_q && is_low) begin
      do_enc    = 1'b1;
      need_push = 1'b1;
      pend_d    = 1'b0;
    end else begin
      do_flush = pend_q;
      if (is_high && !eot) begin
        pend_d    = 1'b1;
        pend_hi_d = in_data_i.code_unit[9:0];
      end else begin
        do_enc = 1'b1;
        pend_d = 1'b0;
      end
      need_push = do_flush || do_enc;
    end

    enc_n = do_enc ? enc.n : 3'd0;
    if (do_flush) begin
      job_o.bytes[0] = enc_fl.b[0];
      job_o.bytes[1] = enc_fl.b[1];
      job_o.bytes[2] = enc_fl.b[2];
      job_o.bytes[3] = enc.b[0];
      job_o.bytes[4] = enc.b[1];
      job_o.bytes[5] = enc.b[2];
      job_o.count    = 3'd3 + enc_n;
    end else begin
      job_o.bytes[0] = enc.b[0];
      job_o.bytes[1] = enc.b[1];
      job_o.bytes[2] = enc.b[2];
      job_o.bytes[3] = enc.b[3];
      job_o.count    = enc_n;
    end
    // zero unit with nothing held: one empty result
    if (is_zero && !do_flush) begin
      job_o.count  = 3'd1;
      job_o.bvalid = 1'b0;
    end else begin
      job_o.bvalid = 1'b1;
    end
    job_o.eos = is_zero || eot;
  end

  assign push_o = accept && need_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      pend_hi_q <= '0;
      stopped_q <= 1'b0;
    end else if (accept) begin
      pend_q    <= pend_d;
      pend_hi_q <= pend_hi_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u16u8_fifo.sv =====
// ----------------------------------------------------------------------------
// u16u8_fifo
// Short job queue between the classifying front and the byte serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf16_to_utf8_encoder_unit_defines.svh"

module u16u8_fifo
  import u16u8_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t wr_job_i,
  input  wire logic pop_i,
  output job_t      rd_job_o,
  output q_stat_t   stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign rd_job_o     = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `U16U8_ASSERT_IMP(a_no_overflow, push_i, !stat_o.full, "job pushed into full queue")
  `U16U8_ASSERT_IMP(a_no_underflow, pop_i, !stat_o.empty, "job popped from empty queue")
  `U16U8_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "queue fill count out of range")

endmodule

`default_nettype wire

// ===== rtl/u16u8_back.sv =====
// ----------------------------------------------------------------------------
// u16u8_back
// Serializes queued jobs into one UTF-8 byte per output transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf16_to_utf8_encoder_unit_defines.svh"

module u16u8_back
  import u16u8_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire job_t    rd_job_i,
  input  wire q_stat_t q_stat_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output out_item_t    out_data_o
);

  job_t       job_q;
  logic       job_v_q;
  logic [2:0] idx_q;
  logic       last, xfer;

  assign last = (idx_q == job_q.count - 3'd1);
  assign xfer = job_v_q && !out_stall_i;
  assign pop_o = !q_stat_i.empty && (!job_v_q || (xfer && last));

  assign out_valid_o              = job_v_q;
  assign out_data_o.out_byte      = job_q.bytes[idx_q];
  assign out_data_o.byte_valid    = job_q.bvalid;
  assign out_data_o.last_of_run   = last;
  assign out_data_o.end_of_string = last && job_q.eos;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= rd_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q <= 1'b0;
      idx_q   <= '0;
    end else if (pop_o) begin
      job_v_q <= 1'b1;
      idx_q   <= '0;
    end else if (xfer) begin
      if (last) begin
        job_v_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  `U16U8_ASSERT_IMP(a_idx_in_job, job_v_q, idx_q < job_q.count, "byte index past job end")
  `U16U8_ASSERT_IMP(a_job_size, job_v_q,
    (job_q.count != 3'd0) && (job_q.count <= 3'(JOB_BYTES)), "job byte count out of range")

endmodule

`default_nettype wire
